[sv/toi_pkg.sv]
// shared types and constants for the tick offset interpolator
package toi_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_USEC_PER_TICK  = 2'd0;
  localparam logic [1:0] CFG_USEC_FRAC      = 2'd1;

  // request command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // field widths
  localparam int unsigned USEC_W = 20;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned DWORD_W = 64;

  // step counter, last step index of each pass
  localparam int unsigned CNT_W = 6;
  localparam logic [CNT_W-1:0] DIV1_LAST = 6'd63;
  localparam logic [CNT_W-1:0] DIV2_LAST = 6'd51;
  localparam logic [CNT_W-1:0] MUL_LAST  = 6'd31;

  // the scaled dividend has 52 significant bits, so the second divide skips 12
  localparam int unsigned DIV2_SKIP = 12;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_QUERY,
    S_DIV1,
    S_DIV1_END,
    S_DIV2,
    S_DIV2_END,
    S_MUL_LOAD,
    S_MUL,
    S_CLAMP,
    S_WRITE
  } state_t;

  typedef enum logic [1:0] {
    UOP_IDLE,
    UOP_LOAD_DIV,
    UOP_LOAD_MUL,
    UOP_STEP
  } uop_t;

  typedef struct packed {
    uop_t               op;
    logic [DWORD_W-1:0] opnd_a;   // dividend or multiplier
    logic [DWORD_W-1:0] opnd_b;   // divisor or multiplicand
  } unit_cmd_t;

  typedef struct packed {
    logic [DWORD_W-1:0] quotient;
    logic [WORD_W-1:0]  prod_hi;
  } unit_res_t;

endpackage

[sv/toi_shift_unit.sv]
// shared add/subtract unit doing one restoring-divide or shift-add multiply step per cycle on a step command
module toi_shift_unit (
  input  logic                 clk,
  input  toi_pkg::unit_cmd_t   ucmd,
  output toi_pkg::unit_res_t   ures
);
  import toi_pkg::*;

  logic               is_div;
  logic [DWORD_W-1:0] acc;    // remainder, or product high word
  logic [DWORD_W-1:0] sh;     // dividend shifting into quotient, or multiplier
  logic [DWORD_W-1:0] opnd;   // divisor or multiplicand

  logic [DWORD_W:0]   rem_sh;
  logic [DWORD_W+1:0] a_in;
  logic [DWORD_W+1:0] b_in;
  logic [DWORD_W+1:0] sum;
  logic               ge;

  always_comb begin
    rem_sh = {acc, sh[DWORD_W-1]};
    if (is_div) begin
      a_in = {1'b0, rem_sh};
      b_in = ~{2'b00, opnd};
    end else begin
      a_in = {{(DWORD_W-WORD_W+2){1'b0}}, acc[WORD_W-1:0]};
      b_in = sh[0] ? {{(DWORD_W-WORD_W+2){1'b0}}, opnd[WORD_W-1:0]} : '0;
    end
    sum = a_in + b_in + {{(DWORD_W+1){1'b0}}, is_div};
    ge  = ~sum[DWORD_W+1];
  end

  always_ff @(posedge clk) begin
    unique case (ucmd.op)
      UOP_LOAD_DIV: begin
        is_div <= 1'b1;
        acc    <= '0;
        sh     <= ucmd.opnd_a;
        opnd   <= ucmd.opnd_b;
      end
      UOP_LOAD_MUL: begin
        is_div <= 1'b0;
        acc    <= '0;
        sh     <= ucmd.opnd_a;
        opnd   <= ucmd.opnd_b;
      end
      UOP_STEP: begin
        if (is_div) begin
          acc <= ge ? sum[DWORD_W-1:0] : rem_sh[DWORD_W-1:0];
          sh  <= {sh[DWORD_W-2:0], ge};
        end else begin
          acc <= {{(DWORD_W-WORD_W){1'b0}}, sum[WORD_W:1]};
          sh  <= {{(DWORD_W-WORD_W){1'b0}}, sum[0], sh[WORD_W-1:1]};
        end
      end
      UOP_IDLE: begin
      end
    endcase
  end

  assign ures.quotient = sh;
  assign ures.prod_hi  = acc[WORD_W-1:0];

endmodule

[sv/tick_offset_interpolator.sv]
// tick offset interpolator top level: handshake, state, sequencer and assertions
//
//  channel   dir  handshake              payload
//  request   in   in_valid / in_ready    cmd, counter_now, tick_count
//  result    out  out_valid / out_ready  offset_usec, clear_counter
//  config    in   cfg_wr_en              cfg_index, cfg_wdata
//
//  a tick request passes the tick and write-back states before its result is valid
//  a query without reciprocal refresh runs the multiply pass only; with refresh it runs
//  the divide passes first; the passes share the add/subtract unit, which retires one
//  quotient bit (64 + 52 steps) or one multiplier bit (32 steps) per cycle
//  rst clears the sequencer, sample words, reciprocal and config to defaults
//  a held result stalls only the write-back; the next request is taken while it waits
module tick_offset_interpolator (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [1:0]                  cfg_index,
  input  logic [toi_pkg::WORD_W-1:0]  cfg_wdata,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        cmd,
  input  logic [toi_pkg::WORD_W-1:0]  counter_now,
  input  logic [toi_pkg::WORD_W-1:0]  tick_count,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [toi_pkg::USEC_W-1:0]  offset_usec,
  output logic                        clear_counter
);
  import toi_pkg::*;

  // configuration registers
  logic [USEC_W-1:0] usec_per_tick;
  logic [WORD_W-1:0] usec_per_tick_frac;

  // architectural state
  logic [WORD_W-1:0] sample_high;
  logic [WORD_W-1:0] sample_low;
  logic [WORD_W-1:0] reciprocal;
  logic [WORD_W-1:0] last_tick_seen;

  // captured request
  logic [WORD_W-1:0] req_now;
  logic [WORD_W-1:0] req_ticks;

  // pending result
  logic [USEC_W-1:0] res_offset;
  logic              res_clear;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  cnt;

  unit_cmd_t         ucmd;
  unit_res_t         ures;

  logic              refresh;     // tick count moved and is nonzero
  logic              out_free;    // output register can take a result
  logic [WORD_W-1:0] delta;

  assign refresh  = (last_tick_seen != req_ticks) && (req_ticks != '0);
  assign out_free = ~out_valid | out_ready;
  assign delta    = req_now - sample_low;   // wraps modulo 2^32

  toi_shift_unit u_unit (
    .clk  (clk),
    .ucmd (ucmd),
    .ures (ures)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (cmd == CMD_QUERY) ? S_QUERY : S_TICK;
        end
      end
      S_TICK:     state_next = S_WRITE;
      S_QUERY:    state_next = refresh ? S_DIV1 : S_MUL_LOAD;
      S_DIV1: begin
        if (cnt == '0) begin
          state_next = S_DIV1_END;
        end
      end
      // zero cycles per tick keeps the old reciprocal
      S_DIV1_END: state_next = (ures.quotient == '0) ? S_MUL_LOAD : S_DIV2;
      S_DIV2: begin
        if (cnt == '0) begin
          state_next = S_DIV2_END;
        end
      end
      S_DIV2_END: state_next = S_MUL_LOAD;
      S_MUL_LOAD: state_next = S_MUL;
      S_MUL: begin
        if (cnt == '0) begin
          state_next = S_CLAMP;
        end
      end
      S_CLAMP:    state_next = S_WRITE;
      S_WRITE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: ready and shared unit command
  always_comb begin
    in_ready    = 1'b0;
    ucmd.op     = UOP_IDLE;
    ucmd.opnd_a = '0;
    ucmd.opnd_b = '0;
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_QUERY: begin
        // cycles per tick = stored 64-bit count / tick count
        if (refresh) begin
          ucmd.op     = UOP_LOAD_DIV;
          ucmd.opnd_a = {sample_high, sample_low};
          ucmd.opnd_b = {{(DWORD_W-WORD_W){1'b0}}, req_ticks};
        end
      end
      S_DIV1_END: begin
        // reciprocal = (usec:frac) / cycles per tick, top 12 zero bits pre-shifted
        if (ures.quotient != '0) begin
          ucmd.op     = UOP_LOAD_DIV;
          ucmd.opnd_a = {usec_per_tick, usec_per_tick_frac, {DIV2_SKIP{1'b0}}};
          ucmd.opnd_b = ures.quotient;
        end
      end
      S_MUL_LOAD: begin
        ucmd.op     = UOP_LOAD_MUL;
        ucmd.opnd_a = {{(DWORD_W-WORD_W){1'b0}}, delta};
        ucmd.opnd_b = {{(DWORD_W-WORD_W){1'b0}}, reciprocal};
      end
      S_DIV1, S_DIV2, S_MUL: ucmd.op = UOP_STEP;
      S_TICK, S_DIV2_END, S_CLAMP, S_WRITE: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_QUERY:                cnt <= DIV1_LAST;
        S_DIV1_END:             cnt <= DIV2_LAST;
        S_MUL_LOAD:             cnt <= MUL_LAST;
        S_DIV1, S_DIV2, S_MUL:  cnt <= cnt - 1'b1;
        default: begin
        end
      endcase
      if (state == S_WRITE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // configuration writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      usec_per_tick      <= USEC_W'(10000);
      usec_per_tick_frac <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_USEC_PER_TICK) begin
        usec_per_tick <= cfg_wdata[USEC_W-1:0];
      end else if (cfg_index == CFG_USEC_FRAC) begin
        usec_per_tick_frac <= cfg_wdata;
      end
    end
  end

  // sample words, reciprocal and last tick seen
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_high    <= '0;
      sample_low     <= '0;
      reciprocal     <= '0;
      last_tick_seen <= '0;
    end else begin
      if (state == S_TICK) begin
        if (req_ticks == '1) begin
          // tick count rolled to all ones: restart the count
          sample_high <= '0;
          sample_low  <= '0;
        end else begin
          if (req_now < sample_low) begin
            sample_high <= sample_high + 1'b1;   // counter wrapped since last tick
          end
          sample_low <= req_now;
        end
      end
      if (state == S_QUERY) begin
        last_tick_seen <= req_ticks;
      end
      if (state == S_DIV2_END) begin
        // quotient above 32 bits saturates
        reciprocal <= (ures.quotient[DWORD_W-1:WORD_W] != '0) ? '1
                                                              : ures.quotient[WORD_W-1:0];
      end
    end
  end

  // request capture, pending result and output payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req_now   <= counter_now;
      req_ticks <= tick_count;
    end
    if (state == S_TICK) begin
      res_offset <= '0;
      res_clear  <= (req_ticks == '1);
    end
    if (state == S_CLAMP) begin
      res_clear <= 1'b0;
      // upper product word, held below usec_per_tick, or zero when usec_per_tick is zero
      if (usec_per_tick == '0) begin
        res_offset <= '0;
      end else if (ures.prod_hi >= {{(WORD_W-USEC_W){1'b0}}, usec_per_tick}) begin
        res_offset <= usec_per_tick - 1'b1;
      end else begin
        res_offset <= ures.prod_hi[USEC_W-1:0];
      end
    end
    if (state == S_WRITE && out_free) begin
      offset_usec   <= res_offset;
      clear_counter <= res_clear;
    end
  end

`ifndef ASSERT_OFF
  // one request in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one still in work");

  // a counter clear request never carries an offset
  a_clear_no_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && clear_counter |-> offset_usec == '0)
    else $error("clear_counter with nonzero offset");

  // offsets stay below one tick
  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && usec_per_tick != '0 |-> offset_usec < usec_per_tick)
    else $error("offset not below usec_per_tick");

  // a multiply pass always starts with a full step count
  a_step_window: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL_LOAD |=> state == S_MUL && cnt == MUL_LAST)
    else $error("multiply pass not started with a full step count");
`endif

endmodule
